>>> hw/rtl/page_bitmap_allocator_assert.svh
// Assertion macros for the page bitmap allocator.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBA_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("page bitmap allocator: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("page bitmap allocator: assertion failed");

`endif

>>> hw/rtl/pba_pkg.sv
`timescale 1ns / 1ps

package pba_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned PAGE_ADDR_W = 22;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned BIT_IDX_W   = 5;
  localparam logic [WORD_BITS-1:0] ALL_USED = 32'hffff_ffff;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_MARK  = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_CLEAR = 2'd3
  } pba_mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } pba_status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RMW
  } pba_state_e;

  // Index of the lowest zero bit; only meaningful when the word is not all ones.
  function automatic logic [BIT_IDX_W-1:0] pba_ffz(input logic [WORD_BITS-1:0] word);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        idx = BIT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> hw/rtl/pba_if.sv
`timescale 1ns / 1ps

interface pba_in_if;
  import pba_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            mode;
  logic [ADDR_W-1:0]     addr;

  modport source (output valid, output mode, output addr, input ready);
  modport sink   (input valid, input mode, input addr, output ready);
endinterface

interface pba_out_if;
  import pba_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [PAGE_ADDR_W-1:0] page_addr;
  logic [1:0]             status;

  modport source (output valid, output page_addr, output status, input ready);
  modport sink   (input valid, input page_addr, input status, output ready);
endinterface

>>> hw/rtl/pba_ram.sv
`timescale 1ns / 1ps

module pba_ram
  import pba_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        addr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/page_bitmap_allocator.sv
`timescale 1ns / 1ps
// Mark/free: read on acceptance, written back in S_RMW; out-of-range: result registered on acceptance;
// clear-all: S_CLEAR writes each bitmap word; allocate: one bitmap word read per cycle until a free bit.
// Throughput: one item at a time; the single-port bitmap memory sets the pace.
// Reset: a clearing pass writes zero to all BITMAP_WORDS words, during which no item is taken.
// The result sits in an output register; the next item is taken as that word is consumed.
module page_bitmap_allocator
  import pba_pkg::*;
#(
  parameter int unsigned PAGE_BYTES   = 4096,
  parameter int unsigned BITMAP_WORDS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pba_in_if.sink   req_i,
  pba_out_if.source rsp_o
);

  // PAGE_BYTES must be a power of two (the block does not check it), so page arithmetic is shifting and masking.
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned WIDX_W     = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int unsigned PAGE_W     = WIDX_W + BIT_IDX_W;
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(BITMAP_WORDS - 1);
  localparam logic [ADDR_W-1:0] OFFS_MASK = ADDR_W'(PAGE_BYTES - 1);

  pba_state_e state_q, state_d;
  logic [WIDX_W-1:0]      word_q, word_d;
  logic [BIT_IDX_W-1:0]   bit_q, bit_d;
  pba_mode_e              mode_q, mode_d;
  logic [PAGE_ADDR_W-1:0] page_q, page_d;
  logic                   report_q, report_d;

  logic                   ovalid_q, ovalid_d;
  logic [PAGE_ADDR_W-1:0] opage_q, opage_d;
  pba_status_e            ostat_q, ostat_d;

  logic                 ram_en, ram_we;
  logic [WIDX_W-1:0]    ram_addr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic                 out_free, accept;
  logic [ADDR_W-1:0]    req_widx, req_page_addr, alloc_addr;
  logic                 req_in_range;
  logic [BIT_IDX_W-1:0] free_bit;
  logic [PAGE_W-1:0]    alloc_page;

  pba_ram #(.DEPTH(BITMAP_WORDS)) u_pba_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_free     = !ovalid_q || rsp_o.ready;
  assign req_i.ready  = (state_q == S_IDLE) && out_free;
  assign accept       = req_i.valid && req_i.ready;

  assign req_widx      = req_i.addr >> (PAGE_SHIFT + BIT_IDX_W);
  assign req_in_range  = req_widx < ADDR_W'(BITMAP_WORDS);
  assign req_page_addr = req_i.addr & ~OFFS_MASK;

  assign free_bit   = pba_ffz(ram_rdata);
  assign alloc_page = {word_q, free_bit};
  assign alloc_addr = ADDR_W'(alloc_page) << PAGE_SHIFT;

  always_comb begin
    state_d   = state_q;
    word_d    = word_q;
    bit_d     = bit_q;
    mode_d    = mode_q;
    page_d    = page_q;
    report_d  = report_q;
    ovalid_d  = ovalid_q && !rsp_o.ready;
    opage_d   = opage_q;
    ostat_d   = ostat_q;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = word_q;
    ram_wdata = '0;

    case (state_q)
      S_CLEAR: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
        if (word_q == LAST_WORD) begin
          state_d = S_IDLE;
          if (report_q) begin
            ovalid_d = 1'b1;
            opage_d  = '0;
            ostat_d  = ST_OK;
          end
          report_d = 1'b0;
        end else begin
          word_d = word_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (pba_mode_e'(req_i.mode))
            MODE_ALLOC: begin
              ram_en   = 1'b1;
              ram_addr = '0;
              word_d   = '0;
              state_d  = S_SCAN;
            end
            MODE_CLEAR: begin
              word_d   = '0;
              report_d = 1'b1;
              state_d  = S_CLEAR;
            end
            default: begin
              if (!req_in_range) begin
                ovalid_d = 1'b1;
                opage_d  = '0;
                ostat_d  = ST_RANGE;
              end else begin
                ram_en   = 1'b1;
                ram_addr = req_widx[WIDX_W-1:0];
                word_d   = req_widx[WIDX_W-1:0];
                bit_d    = req_i.addr[PAGE_SHIFT +: BIT_IDX_W];
                mode_d   = pba_mode_e'(req_i.mode);
                page_d   = req_page_addr[PAGE_ADDR_W-1:0];
                state_d  = S_RMW;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // ram_rdata holds the word at word_q, read in the previous cycle.
        if (ram_rdata != ALL_USED) begin
          ram_en    = 1'b1;
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | (WORD_BITS'(1) << free_bit);
          ovalid_d  = 1'b1;
          opage_d   = alloc_addr[PAGE_ADDR_W-1:0];
          ostat_d   = ST_OK;
          state_d   = S_IDLE;
        end else if (word_q == LAST_WORD) begin
          ovalid_d = 1'b1;
          opage_d  = '0;
          ostat_d  = ST_FULL;
          state_d  = S_IDLE;
        end else begin
          ram_en   = 1'b1;
          ram_addr = word_q + 1'b1;
          word_d   = word_q + 1'b1;
        end
      end
      S_RMW: begin
        // The write lands before any later read, so no forwarding is needed.
        ram_en = 1'b1;
        ram_we = 1'b1;
        if (mode_q == MODE_MARK) begin
          ram_wdata = ram_rdata | (WORD_BITS'(1) << bit_q);
        end else begin
          ram_wdata = ram_rdata & ~(WORD_BITS'(1) << bit_q);
        end
        ovalid_d = 1'b1;
        opage_d  = page_q;
        ostat_d  = ST_OK;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      word_q   <= '0;
      report_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      word_q   <= word_d;
      report_q <= report_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q   <= bit_d;
    mode_q  <= mode_d;
    page_q  <= page_d;
    opage_q <= opage_d;
    ostat_q <= ostat_d;
  end

  assign rsp_o.valid     = ovalid_q;
  assign rsp_o.page_addr = opage_q;
  assign rsp_o.status    = ostat_q;

endmodule

>>> hw/rtl/pba_checker.sv
`timescale 1ns / 1ps
`include "page_bitmap_allocator_assert.svh"

module pba_checker
  import pba_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   req_ready_i,
  input logic                   rsp_valid_i,
  input logic                   rsp_ready_i,
  input logic [PAGE_ADDR_W-1:0] rsp_page_addr_i,
  input logic [1:0]             rsp_status_i
);

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);

  // A status code of 3 is never produced.
  `PBA_ASSERT(a_status_legal, rsp_valid_i, rsp_status_i != 2'd3)

  // Error results carry a zero address.
  `PBA_ASSERT(a_err_zero, rsp_valid_i && (rsp_status_i != ST_OK), rsp_page_addr_i == '0)

  // Every reported address is page aligned.
  `PBA_ASSERT(a_aligned, rsp_valid_i, rsp_page_addr_i[PAGE_SHIFT-1:0] == '0)

  // No new word is taken while a result waits and is not consumed.
  `PBA_ASSERT(a_no_take_stalled, rsp_valid_i && !rsp_ready_i, !req_ready_i)

  // A stalled result holds.
  `PBA_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_page_addr_i) && $stable(rsp_status_i))

endmodule

bind page_bitmap_allocator pba_checker #(.PAGE_BYTES(PAGE_BYTES)) u_pba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_page_addr_i (rsp_o.page_addr),
  .rsp_status_i    (rsp_o.status)
);
